// ===== rtl/core/sequential_list_engine_top_macros.svh =====
// Assertion shorthands shared by the list engine modules.
// Every macro samples on clk_i and is switched off while rst_ni is low.
`ifndef SEQUENTIAL_LIST_ENGINE_TOP_MACROS_SVH
`define SEQUENTIAL_LIST_ENGINE_TOP_MACROS_SVH

// Check that a condition holds at every clock edge.
`define SLE_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// Check that a trigger is followed by a consequence (non-overlapping implication).
`define SLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sle_pkg.sv =====
package sle_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 7;
  localparam int LEN_W    = 7;
  localparam int KIND_W   = 2;
  localparam int STAT_W   = 2;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ADDR_W   = $clog2(CAPACITY);
  // wide enough for position, count and count + 1 without wrapping
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_READ   = 2'd2
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT,
    S_DRAIN,
    S_COMMIT,
    S_RESP
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load_in;   // capture the input word
    logic decide;    // latch the status of the held word
    logic start;     // set the shift pointer
    logic step;      // move one entry
    logic commit;    // final write and length update
    logic rd_issue;  // read the addressed entry
    logic load_out;  // fill the output register
  } sle_cmd_t;

  // datapath to controller
  typedef struct packed {
    status_e             status;
    logic [KIND_W-1:0]   kind;
    logic                need_shift;
    logic                last;
    logic                out_free;
  } sle_sts_t;

endpackage

// ===== rtl/core/sle_ctrl.sv =====
module sle_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sle_pkg::sle_sts_t sts_i,
  output sle_pkg::sle_cmd_t cmd_o
);
  import sle_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.decide = 1'b1;
        if (sts_i.status != ST_OK) begin
          state_d = S_RESP;
        end else begin
          case (sts_i.kind)
            KIND_INSERT, KIND_DELETE: begin
              if (sts_i.need_shift) begin
                cmd_o.start = 1'b1;
                state_d     = S_SHIFT;
              end else begin
                state_d = S_COMMIT;
              end
            end
            KIND_READ: begin
              cmd_o.rd_issue = 1'b1;
              state_d        = S_RESP;
            end
            default: state_d = S_RESP;
          endcase
        end
      end
      S_SHIFT: begin
        cmd_o.step = 1'b1;
        if (sts_i.last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // let the last moved entry land
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_RESP;
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/sle_dpath.sv =====
module sle_dpath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  sle_pkg::sle_cmd_t                  cmd_i,
  output sle_pkg::sle_sts_t                  sts_o,
  input  logic [sle_pkg::KIND_W-1:0]         kind_i,
  input  logic [sle_pkg::POS_W-1:0]          position_i,
  input  logic signed [sle_pkg::DATA_W-1:0]  value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [sle_pkg::STAT_W-1:0]         status_o,
  output logic signed [sle_pkg::DATA_W-1:0]  read_value_o,
  output logic [sle_pkg::LEN_W-1:0]          length_o
);
  import sle_pkg::*;

  `include "sequential_list_engine_top_macros.svh"

  logic [KIND_W-1:0]        kind_q;
  logic [POS_W-1:0]         pos_q;
  logic signed [DATA_W-1:0] value_q;
  logic [CNT_W-1:0]         count_q;
  status_e                  status_q, status_d;
  logic [ADDR_W-1:0]        ptr_q;
  logic                     wr_pend_q;
  logic [ADDR_W-1:0]        wr_addr_q;
  logic [DATA_W-1:0]        rdata_q;
  logic [DATA_W-1:0]        mem [CAPACITY];

  logic                     out_valid_q;
  logic [STAT_W-1:0]        out_status_q;
  logic signed [DATA_W-1:0] out_value_q;
  logic [LEN_W-1:0]         out_len_q;

  logic [CMP_W-1:0]  posx, cntx;
  logic [ADDR_W-1:0] pidx, top_idx;
  logic              is_ins;
  logic              re, we;
  logic [ADDR_W-1:0] ra, wa;
  logic [DATA_W-1:0] wd;

  assign posx    = CMP_W'(pos_q);
  assign cntx    = CMP_W'(count_q);
  assign pidx    = ADDR_W'(posx - CMP_W'(1));
  assign top_idx = ADDR_W'(cntx - CMP_W'(1));
  assign is_ins  = (kind_q == KIND_INSERT);

  // status of the held word against the current length
  always_comb begin
    case (kind_q)
      KIND_INSERT: begin
        if (cntx >= CMP_W'(CAPACITY)) begin
          status_d = ST_FULL;
        end else if (posx == '0 || posx > cntx + CMP_W'(1)) begin
          status_d = ST_BADPOS;
        end else begin
          status_d = ST_OK;
        end
      end
      KIND_DELETE, KIND_READ: begin
        if (cntx == '0) begin
          status_d = ST_EMPTY;
        end else if (posx == '0 || posx > cntx) begin
          status_d = ST_BADPOS;
        end else begin
          status_d = ST_OK;
        end
      end
      default: status_d = ST_BADPOS;
    endcase
  end

  assign sts_o.status     = status_d;
  assign sts_o.kind       = kind_q;
  assign sts_o.need_shift = is_ins ? (posx <= cntx) : (posx < cntx);
  assign sts_o.last       = is_ins ? (ptr_q == pidx) : (ptr_q == top_idx);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // memory ports: one read, one write per cycle
  assign re = cmd_i.step || cmd_i.rd_issue;
  assign ra = cmd_i.step ? ptr_q : pidx;
  assign we = wr_pend_q || (cmd_i.commit && is_ins);
  assign wa = wr_pend_q ? wr_addr_q : pidx;
  assign wd = wr_pend_q ? rdata_q : value_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rdata_q <= mem[ra];
    end
  end

  // held word and shift pointer
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      kind_q  <= kind_i;
      pos_q   <= position_i;
      value_q <= value_i;
    end
    if (cmd_i.decide) begin
      status_q <= status_d;
    end
    if (cmd_i.start) begin
      ptr_q <= is_ins ? top_idx : ADDR_W'(posx);
    end else if (cmd_i.step) begin
      ptr_q <= is_ins ? ptr_q - ADDR_W'(1) : ptr_q + ADDR_W'(1);
    end
    if (cmd_i.step) begin
      wr_addr_q <= is_ins ? ptr_q + ADDR_W'(1) : ptr_q - ADDR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      wr_pend_q <= 1'b0;
    end else begin
      wr_pend_q <= cmd_i.step;
      if (cmd_i.commit) begin
        count_q <= is_ins ? count_q + CNT_W'(1) : count_q - CNT_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_q <= status_q;
      out_value_q  <= (kind_q == KIND_READ && status_q == ST_OK) ? rdata_q : '0;
      out_len_q    <= LEN_W'(count_q);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign read_value_o = out_value_q;
  assign length_o     = out_len_q;

  `SLE_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(CAPACITY), "count above capacity")
  `SLE_ASSERT_ALWAYS(a_port_clash, !(wr_pend_q && cmd_i.commit), "commit overlaps shift write")
  `SLE_ASSERT_ALWAYS(a_raw_clash, !(wr_pend_q && re && wr_addr_q == ra), "read hits pending write")
  `SLE_ASSERT_NEXT(a_ins_grow, cmd_i.commit && is_ins, count_q == $past(count_q) + CNT_W'(1), "insert did not grow list")

endmodule

// ===== rtl/core/sequential_list_engine_top.sv =====
// Ordered list engine: holds up to 64 signed 32-bit entries addressed by
// one-based positions. Each input word is an insert (kind 0), a delete
// (kind 1) or a read (kind 2) and yields exactly one output word carrying a
// status (0 ok, 1 full, 2 bad position, 3 empty), the entry read on a good
// read (zero otherwise) and the list length after the operation. A full
// list is reported before a bad position on insert, an empty list before a
// bad position on delete or read; any failed operation leaves the list as
// it was. Words are handled one at a time. A read or any failed operation
// goes from the check state straight to the response state, which loads
// the output register once it is free; the block then returns to idle.
// A good insert at position p into a list of n entries moves n - p + 1
// entries and a good delete n - p, one per cycle, since the list store is a
// single-port read, single-port write memory and every moved entry passes
// through it. A word that moves entries goes through the check, shift,
// drain, commit and response states; an insert at the end or a delete of
// the last entry moves nothing and skips the shift and drain states.
// The worst case moves 63 entries. The result sits in an output register,
// so the next input word is taken while it waits for the sink; a second
// result waiting behind it holds the input off until the sink takes the
// first.
// After reset the list is empty; no clearing pass is needed.
module sequential_list_engine_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [sle_pkg::KIND_W-1:0]         kind_i,
  input  logic [sle_pkg::POS_W-1:0]          position_i,
  input  logic signed [sle_pkg::DATA_W-1:0]  value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [sle_pkg::STAT_W-1:0]         status_o,
  output logic signed [sle_pkg::DATA_W-1:0]  read_value_o,
  output logic [sle_pkg::LEN_W-1:0]          length_o
);
  import sle_pkg::*;

  sle_cmd_t cmd;
  sle_sts_t sts;

  // sequencing: accept, check, shift, commit, hand over
  sle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // list store, length counter, checks and output register
  sle_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .kind_i       (kind_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .read_value_o (read_value_o),
    .length_o     (length_o)
  );

endmodule

// ===== test/tb_sequential_list_engine_top.sv =====
`timescale 1ns / 100ps

module tb_sequential_list_engine_top;
  import sle_pkg::*;

  // Kind 3 carries no operation; the block must answer it as a bad position.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int WORDS_PER_PHASE = 232;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 80;

  typedef struct {
    status_e                   status;
    logic signed [DATA_W-1:0]  value;
    logic [LEN_W-1:0]          length;
  } list_answer_t;

  // Shadow copy of the list: apply each accepted word, queue the answer it
  // must produce, and match answers from the block against that queue.
  class list_shadow;
    logic signed [DATA_W-1:0] slots [CAPACITY];
    int unsigned              len;
    list_answer_t             pending_words [$];
    int unsigned              mismatches;

    function new();
      len = 0;
      mismatches = 0;
    endfunction

    function void apply_word(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                             logic signed [DATA_W-1:0] val);
      list_answer_t a;
      int p;
      p = pos;
      a.status = ST_OK;
      a.value  = '0;
      case (kind)
        KIND_INSERT: begin
          if (len >= CAPACITY) begin
            a.status = ST_FULL;
          end else if (p < 1 || p > len + 1) begin
            a.status = ST_BADPOS;
          end else begin
            // open a gap from the top down
            for (int k = len; k >= p; k--) slots[k] = slots[k-1];
            slots[p-1] = val;
            len++;
          end
        end
        KIND_DELETE: begin
          if (len == 0) begin
            a.status = ST_EMPTY;
          end else if (p < 1 || p > len) begin
            a.status = ST_BADPOS;
          end else begin
            for (int k = p; k < len; k++) slots[k-1] = slots[k];
            len--;
          end
        end
        KIND_READ: begin
          if (len == 0) begin
            a.status = ST_EMPTY;
          end else if (p < 1 || p > len) begin
            a.status = ST_BADPOS;
          end else begin
            a.value = slots[p-1];
          end
        end
        default: a.status = ST_BADPOS;
      endcase
      a.length = LEN_W'(len);
      pending_words.push_back(a);
    endfunction

    function void match_word(logic [STAT_W-1:0] status, logic signed [DATA_W-1:0] value,
                             logic [LEN_W-1:0] length);
      list_answer_t a;
      if (pending_words.size() == 0) begin
        $error("result word with no word outstanding: status %0d value %0d length %0d",
               status, value, length);
        mismatches++;
        return;
      end
      a = pending_words.pop_front();
      if (status !== a.status) begin
        $error("status: expected %0d, got %0d", a.status, status);
        mismatches++;
      end
      if (value !== a.value) begin
        $error("read_value: expected %0d, got %0d", a.value, value);
        mismatches++;
      end
      if (length !== a.length) begin
        $error("length: expected %0d, got %0d", a.length, length);
        mismatches++;
      end
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic [KIND_W-1:0]          kind_i;
  logic [POS_W-1:0]           position_i;
  logic signed [DATA_W-1:0]   value_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic [STAT_W-1:0]          status_o;
  logic signed [DATA_W-1:0]   read_value_o;
  logic [LEN_W-1:0]           length_o;

  list_shadow shadow = new();

  int unsigned tx_idle_pct = 0;   // chance per cycle that the sender sits idle
  int unsigned rx_stall_pct = 0;  // chance per cycle that the receiver stalls
  bit          rx_hold_req = 1'b0;
  bit          filling = 1'b1;    // random words lean towards growing the list

  sequential_list_engine_top u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .read_value_o (read_value_o),
    .length_o     (length_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Receiver: stall at random, or hold off for a long stretch on request so
  // that the block backs up and drops in_ready_o while words keep coming.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Check every result word taken by the receiver; values seen here are
  // those from just before the edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      shadow.match_word(status_o, read_value_o, length_o);
    end
  end

  // Offer one word: idle first at random, then hold valid and the payload
  // until the handshake, and apply the word to the shadow list.
  task automatic send_word(input logic [KIND_W-1:0] k, input logic [POS_W-1:0] p,
                           input logic signed [DATA_W-1:0] v);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid_i <= 1'b1;
    kind_i     <= k;
    position_i <= p;
    value_i    <= v;
    do @(posedge clk_i); while (!in_ready_o);
    shadow.apply_word(k, p, v);
  endtask

  // Stop offering and wait until every outstanding result has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (shadow.pending_words.size() != 0) @(posedge clk_i);
  endtask

  // Build one random word. Most positions are in range so that the list
  // fills to capacity and empties again; the rest are zero, sit just past
  // the end or fall anywhere in the field.
  task automatic send_random_word();
    int unsigned n;
    int unsigned pick;
    int unsigned hi;
    logic [KIND_W-1:0] k;
    logic [POS_W-1:0]  p;
    n = shadow.len;
    if (n == CAPACITY) filling = 1'b0;
    else if (n == 0) filling = 1'b1;
    pick = $urandom_range(99);
    if (pick < 2) k = KIND_UNUSED;
    else if (pick < (filling ? 70 : 30)) k = KIND_INSERT;
    else if (pick < (filling ? 85 : 75)) k = KIND_DELETE;
    else k = KIND_READ;
    hi = (k == KIND_INSERT) ? n + 1 : n;
    case ($urandom_range(9))
      0: p = POS_W'($urandom_range(127));
      1: p = ($urandom_range(1) == 0) ? '0 : POS_W'(hi + 1);
      default: p = (hi == 0) ? '0 : POS_W'($urandom_range(hi, 1));
    endcase
    send_word(k, p, $urandom);
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    kind_i     = KIND_INSERT;
    position_i = '0;
    value_i    = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words: empty list, position edges, front, middle and end
    // inserts, extreme values, the unused kind, and deletes at each end.
    send_word(KIND_READ,   7'd1,   32'sd5);
    send_word(KIND_DELETE, 7'd1,   32'sd0);
    send_word(KIND_DELETE, 7'd0,   32'sd0);
    send_word(KIND_INSERT, 7'd0,   32'sd11);
    send_word(KIND_INSERT, 7'd2,   32'sd12);
    send_word(KIND_INSERT, 7'd127, 32'sd13);
    send_word(KIND_INSERT, 7'd1,   32'sh8000_0000);
    send_word(KIND_INSERT, 7'd1,   32'sh7fff_ffff);
    send_word(KIND_INSERT, 7'd3,   -32'sd1);
    send_word(KIND_INSERT, 7'd2,   32'sd0);
    send_word(KIND_READ,   7'd0,   32'sd0);
    send_word(KIND_READ,   7'd5,   32'sd0);
    send_word(KIND_READ,   7'd127, -32'sd1);
    for (int i = 1; i <= 4; i++) send_word(KIND_READ, POS_W'(i), 32'sd0);
    send_word(KIND_UNUSED, 7'd127, -32'sd1);
    send_word(KIND_UNUSED, 7'd0,   32'sd0);
    send_word(KIND_DELETE, 7'd5,   32'sd0);
    send_word(KIND_DELETE, 7'd4,   32'sd0);
    send_word(KIND_DELETE, 7'd1,   32'sd0);
    send_word(KIND_DELETE, 7'd2,   32'sd0);
    send_word(KIND_READ,   7'd1,   32'sd0);
    send_word(KIND_DELETE, 7'd1,   32'sd0);
    send_word(KIND_READ,   7'd1,   32'sd0);
    drain_results();

    // Random phases, each with its own idling mix; drain between them.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 59; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 59; end
        default: begin tx_idle_pct = 15; rx_stall_pct = 15; end
      endcase
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        // halfway through the stalling phase, hold the receiver off and
        // push a back-to-back burst so the block fills and stalls its input
        if (ph == 2 && i == WORDS_PER_PHASE / 2) begin
          tx_idle_pct = 0;
          rx_hold_req = 1'b1;
          repeat (12) send_random_word();
          tx_idle_pct = 0;
        end
        send_random_word();
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (shadow.mismatches == 0 && shadow.pending_words.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
